/* rtl/rv32d_pkg.sv */
// Shared types and opcode constants for the RV32I instruction decoder.
`default_nettype none

package rv32d_pkg;

  localparam int unsigned InstrW = 32;
  localparam int unsigned RegW   = 5;
  localparam int unsigned FuncW  = 10;

  localparam logic [6:0] OpcReg    = 7'b0110011;
  localparam logic [6:0] OpcAluImm = 7'b0010011;
  localparam logic [6:0] OpcLoad   = 7'b0000011;
  localparam logic [6:0] OpcJalr   = 7'b1100111;
  localparam logic [6:0] OpcStore  = 7'b0100011;
  localparam logic [6:0] OpcBranch = 7'b1100011;
  localparam logic [6:0] OpcAuipc  = 7'b0010111;
  localparam logic [6:0] OpcLui    = 7'b0110111;
  localparam logic [6:0] OpcJal    = 7'b1101111;

  localparam logic [2:0] F3Sll = 3'b001;
  localparam logic [2:0] F3Sr  = 3'b101;

  typedef enum logic [3:0] {
    FMT_REG    = 4'd0,
    FMT_ALUIMM = 4'd1,
    FMT_SHIFT  = 4'd2,
    FMT_LOAD   = 4'd3,
    FMT_JALR   = 4'd4,
    FMT_STORE  = 4'd5,
    FMT_BRANCH = 4'd6,
    FMT_AUIPC  = 4'd7,
    FMT_LUI    = 4'd8,
    FMT_JAL    = 4'd9
  } fmt_kind_e;

  typedef struct packed {
    fmt_kind_e          kind;
    logic [RegW-1:0]    rd;
    logic [RegW-1:0]    rs1;
    logic [RegW-1:0]    rs2;
    logic [FuncW-1:0]   func;
    logic [InstrW-1:0]  imm;
    logic               illegal;
  } dec_result_t;

endpackage

`default_nettype wire

/* rtl/rv32d_decode.sv */
// Combinational field extraction and immediate assembly for one instruction word.
`default_nettype none

module rv32d_decode (
  input  wire logic [rv32d_pkg::InstrW-1:0] instr_i,
  output rv32d_pkg::dec_result_t            result_o
);
  import rv32d_pkg::*;

  logic [6:0]        opc;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [InstrW-1:0] imm_i;
  logic [InstrW-1:0] imm_s;
  logic [InstrW-1:0] imm_b;
  logic [InstrW-1:0] imm_u;
  logic [InstrW-1:0] imm_j;
  logic [InstrW-1:0] imm_sh;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign f7  = instr_i[31:25];

  assign imm_i  = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s  = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b  = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                   instr_i[11:8], 1'b0};
  assign imm_u  = {instr_i[31:12], 12'b0};
  assign imm_j  = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                   instr_i[30:21], 1'b0};
  assign imm_sh = {27'b0, instr_i[24:20]};

  always_comb begin
    result_o = '0;
    case (opc)
      OpcReg: begin
        result_o.kind = FMT_REG;
        result_o.rd   = instr_i[11:7];
        result_o.rs1  = instr_i[19:15];
        result_o.rs2  = instr_i[24:20];
        result_o.func = {f3, f7};
      end
      OpcAluImm: begin
        result_o.rd  = instr_i[11:7];
        result_o.rs1 = instr_i[19:15];
        if (f3 == F3Sll || f3 == F3Sr) begin
          result_o.kind = FMT_SHIFT;
          result_o.func = {f3, f7};
          result_o.imm  = imm_sh;
        end else begin
          result_o.kind = FMT_ALUIMM;
          result_o.func = {f3, 7'b0};
          result_o.imm  = imm_i;
        end
      end
      OpcLoad, OpcJalr: begin
        result_o.kind = (opc == OpcLoad) ? FMT_LOAD : FMT_JALR;
        result_o.rd   = instr_i[11:7];
        result_o.rs1  = instr_i[19:15];
        result_o.func = {f3, 7'b0};
        result_o.imm  = imm_i;
      end
      OpcStore: begin
        result_o.kind = FMT_STORE;
        result_o.rs1  = instr_i[19:15];
        result_o.rs2  = instr_i[24:20];
        result_o.func = {f3, 7'b0};
        result_o.imm  = imm_s;
      end
      OpcBranch: begin
        result_o.kind = FMT_BRANCH;
        result_o.rs1  = instr_i[19:15];
        result_o.rs2  = instr_i[24:20];
        result_o.func = {f3, 7'b0};
        result_o.imm  = imm_b;
      end
      OpcAuipc, OpcLui: begin
        result_o.kind = (opc == OpcAuipc) ? FMT_AUIPC : FMT_LUI;
        result_o.rd   = instr_i[11:7];
        result_o.imm  = imm_u;
      end
      OpcJal: begin
        result_o.kind = FMT_JAL;
        result_o.rd   = instr_i[11:7];
        result_o.imm  = imm_j;
      end
      default: begin
        result_o.illegal = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rv32i_instruction_decoder.sv */
// Top level: input register, decode logic and result register of the RV32I decoder.
//
//   channel  direction  handshake                 payload
//   in       request in in_valid_i / in_stall_o   instr_word_i
//   out      result out out_valid_o / out_stall_i format_kind_o .. illegal_op_o
//
// One request per cycle sustained while out is not stalled; an accepted request is held in the
// input register and then in the result register, which drives out_valid_o.
// The decode logic sits between the input register and the result register.
// rst_ni clears both valid flags; payload registers are not reset.
// A stall on out propagates to in_stall_o in the same cycle only when both stages hold data.
`default_nettype none

module rv32i_instruction_decoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [rv32d_pkg::InstrW-1:0]      instr_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [3:0]                             format_kind_o,
  output logic [rv32d_pkg::RegW-1:0]             dest_reg_o,
  output logic [rv32d_pkg::RegW-1:0]             src_reg_a_o,
  output logic [rv32d_pkg::RegW-1:0]             src_reg_b_o,
  output logic [rv32d_pkg::FuncW-1:0]            func_code_o,
  output logic signed [rv32d_pkg::InstrW-1:0]    imm_value_o,
  output logic                                   illegal_op_o
);
  import rv32d_pkg::*;

  logic              in_valid_q;
  logic [InstrW-1:0] instr_q;
  logic              out_valid_q;
  dec_result_t       res_d;
  dec_result_t       res_q;
  logic              out_adv;
  logic              in_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      instr_q <= instr_word_i;
    end
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  rv32d_decode u_decode (
    .instr_i  (instr_q),
    .result_o (res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign format_kind_o = res_q.kind;
  assign dest_reg_o    = res_q.rd;
  assign src_reg_a_o   = res_q.rs1;
  assign src_reg_b_o   = res_q.rs2;
  assign func_code_o   = res_q.func;
  assign imm_value_o   = $signed(res_q.imm);
  assign illegal_op_o  = res_q.illegal;

  // stall only while the input stage holds a request
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stall with empty input stage");

  // a decoded request moving forward shows up on out next cycle
  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv) |=> out_valid_o)
    else $error("decoded request lost");

  // unknown opcode leaves every other field zero
  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && illegal_op_o) |->
      (format_kind_o == 4'd0 && dest_reg_o == '0 && src_reg_a_o == '0 &&
       src_reg_b_o == '0 && func_code_o == '0 && imm_value_o == '0))
    else $error("illegal opcode with nonzero fields");

  // store and branch have no destination
  a_no_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (format_kind_o == FMT_STORE || format_kind_o == FMT_BRANCH))
      |-> dest_reg_o == '0)
    else $error("store or branch with destination register");

endmodule

`default_nettype wire
